// ===== src/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SSP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ssp assertion failed");
`define SSP_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("ssp assertion failed");
`else
`define SSP_ASSERT(label, clk, rst, prop)
`define SSP_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== src/ssp_pkg.sv =====
package ssp_pkg;

   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_HOME = 2'd1;
   localparam logic [1:0] OP_GOTO = 2'd2;

   localparam logic [2:0] REG_STEPS_PER_SLOT  = 3'd0;
   localparam logic [2:0] REG_HOME_BACKOFF    = 3'd1;
   localparam logic [2:0] REG_FIRST_LIMIT     = 3'd2;
   localparam logic [2:0] REG_DIR_SETTLE      = 3'd3;
   localparam logic [2:0] REG_HOME_SETTLE     = 3'd4;
   localparam logic [2:0] REG_ARRIVAL_PAUSE   = 3'd5;
   localparam logic [2:0] REG_MAX_SLOT        = 3'd6;
   localparam logic [2:0] REG_STEP_HALF       = 3'd7;

   localparam logic [9:0]  RST_STEPS_PER_SLOT = 10'd150;
   localparam logic [7:0]  RST_HOME_BACKOFF   = 8'd10;
   localparam logic [7:0]  RST_FIRST_LIMIT    = 8'd15;
   localparam logic [11:0] RST_DIR_SETTLE     = 12'd100;
   localparam logic [11:0] RST_HOME_SETTLE    = 12'd100;
   localparam logic [11:0] RST_ARRIVAL_PAUSE  = 12'd1000;
   localparam logic [2:0]  RST_MAX_SLOT       = 3'd6;
   localparam logic [7:0]  RST_STEP_HALF      = 8'd1;

   typedef struct packed {
      logic [9:0]  steps_per_slot;
      logic [7:0]  home_backoff_steps;
      logic [7:0]  first_slot_limit;
      logic [11:0] dir_settle_ticks;
      logic [11:0] home_settle_ticks;
      logic [11:0] arrival_pause_ticks;
      logic [2:0]  max_slot;
      logic [7:0]  step_half_ticks;
   } cfg_type;

   typedef struct packed {
      logic [2:0] slot;
      logic       busy_res;
      logic       dir_pin;
      logic       step_pin;
   } rsp_type;

endpackage

// ===== src/ssp_cfg_regs.sv =====
module ssp_cfg_regs
   import ssp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_data,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_STEPS_PER_SLOT: cfg_in.steps_per_slot      = csr_data[9:0];
            REG_HOME_BACKOFF:   cfg_in.home_backoff_steps  = csr_data[7:0];
            REG_FIRST_LIMIT:    cfg_in.first_slot_limit    = csr_data[7:0];
            REG_DIR_SETTLE:     cfg_in.dir_settle_ticks    = csr_data;
            REG_HOME_SETTLE:    cfg_in.home_settle_ticks   = csr_data;
            REG_ARRIVAL_PAUSE:  cfg_in.arrival_pause_ticks = csr_data;
            REG_MAX_SLOT:       cfg_in.max_slot            = csr_data[2:0];
            REG_STEP_HALF:      cfg_in.step_half_ticks     = csr_data[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.steps_per_slot      <= RST_STEPS_PER_SLOT;
         cfg_ff.home_backoff_steps  <= RST_HOME_BACKOFF;
         cfg_ff.first_slot_limit    <= RST_FIRST_LIMIT;
         cfg_ff.dir_settle_ticks    <= RST_DIR_SETTLE;
         cfg_ff.home_settle_ticks   <= RST_HOME_SETTLE;
         cfg_ff.arrival_pause_ticks <= RST_ARRIVAL_PAUSE;
         cfg_ff.max_slot            <= RST_MAX_SLOT;
         cfg_ff.step_half_ticks     <= RST_STEP_HALF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/ssp_core.sv =====
module ssp_core
   import ssp_pkg::*;
#(
   parameter int TICK_TIMER_BITS = 12
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic [1:0] operation,
   input  logic [2:0] target,
   input  logic       near_limit,
   input  logic       far_limit,
   input  cfg_type    cfg,
   output rsp_type    rsp_next
);

   localparam int TB = TICK_TIMER_BITS;
   localparam int SW = (TB > 12) ? TB : 12;
   localparam logic [SW-1:0] TIMER_MAX_W = SW'((64'd1 << TB) - 64'd1);

   typedef enum logic [3:0] {
      PH_IDLE, PH_H_DIR, PH_H_SEEK, PH_H_SETL, PH_H_RDIR, PH_H_BACK,
      PH_G_DIR1, PH_G_FIRST, PH_G_PAUSE, PH_G_DIR2, PH_G_MOVE
   } phase_type;

   function automatic logic [TB-1:0] sat_ticks(input logic [11:0] t);
      logic [SW-1:0] wide;
      wide = SW'(t);
      if (wide > TIMER_MAX_W) begin
         wide = TIMER_MAX_W;
      end
      return wide[TB-1:0];
   endfunction

   phase_type     phase_ff, phase_in;
   logic [2:0]    slot_ff, slot_in;
   logic [2:0]    goal_ff, goal_in;
   logic [12:0]   left_ff, left_in;
   logic [TB-1:0] timer_ff, timer_in;
   logic          dir_ff, dir_in;
   logic          step_ff, step_in;

   logic [TB-1:0] tdec;
   logic          wait_done;
   logic          go_on;
   logic          st_done;
   logic [TB-1:0] st_timer;
   logic          st_step;
   logic [12:0]   st_left;
   logic [TB-1:0] half;

   logic [2:0]    plan_goal;
   logic [2:0]    clamp_goal;
   logic [2:0]    diff;
   logic [12:0]   plan_steps;
   logic          any_limit;

   assign any_limit  = near_limit | far_limit;
   assign half       = sat_ticks({4'd0, cfg.step_half_ticks});
   assign tdec       = (timer_ff != '0) ? timer_ff - TB'(1) : '0;
   assign wait_done  = (tdec == '0);
   assign clamp_goal = (target > cfg.max_slot) ? cfg.max_slot : target;
   assign plan_goal  = (phase_ff == PH_IDLE) ? clamp_goal : goal_ff;
   assign diff       = (plan_goal < slot_ff) ? slot_ff - plan_goal : plan_goal - slot_ff;
   assign plan_steps = {3'd0, cfg.steps_per_slot} * {10'd0, diff};

   always_comb begin
      case (phase_ff)
         PH_H_SEEK:             go_on = ~far_limit;
         PH_H_BACK:             go_on = (left_ff != '0);
         PH_G_FIRST, PH_G_MOVE: go_on = (left_ff != '0) & ~any_limit;
         default:               go_on = 1'b0;
      endcase
   end

   // one tick of a stepping phase
   always_comb begin
      st_done  = 1'b0;
      st_timer = tdec;
      st_step  = step_ff;
      st_left  = left_ff;
      if (tdec == '0) begin
         if (step_ff) begin
            st_step  = 1'b0;
            st_timer = half;
         end else if (!go_on) begin
            st_done = 1'b1;
         end else begin
            st_step  = 1'b1;
            st_timer = half;
            if (left_ff != '0) begin
               st_left = left_ff - 13'd1;
            end
         end
      end
   end

   always_comb begin
      phase_in = phase_ff;
      slot_in  = slot_ff;
      goal_in  = goal_ff;
      left_in  = left_ff;
      timer_in = timer_ff;
      dir_in   = dir_ff;
      step_in  = step_ff;
      if (operation == OP_TICK) begin
         if (phase_ff != PH_IDLE) begin
            case (phase_ff)
               PH_H_DIR: begin
                  timer_in = tdec;
                  if (wait_done) begin
                     phase_in = PH_H_SEEK;
                     left_in  = '0;
                     timer_in = '0;
                     step_in  = 1'b0;
                  end
               end
               PH_H_SEEK: begin
                  timer_in = st_timer;
                  step_in  = st_step;
                  left_in  = st_left;
                  if (st_done) begin
                     phase_in = PH_H_SETL;
                     timer_in = sat_ticks(cfg.home_settle_ticks);
                     step_in  = 1'b0;
                  end
               end
               PH_H_SETL: begin
                  timer_in = tdec;
                  if (wait_done) begin
                     dir_in   = 1'b0;
                     phase_in = PH_H_RDIR;
                     timer_in = sat_ticks(cfg.dir_settle_ticks);
                     step_in  = 1'b0;
                  end
               end
               PH_H_RDIR: begin
                  timer_in = tdec;
                  if (wait_done) begin
                     phase_in = PH_H_BACK;
                     left_in  = {5'd0, cfg.home_backoff_steps};
                     timer_in = '0;
                     step_in  = 1'b0;
                  end
               end
               PH_H_BACK: begin
                  timer_in = st_timer;
                  step_in  = st_step;
                  left_in  = st_left;
                  if (st_done) begin
                     slot_in  = '0;
                     phase_in = PH_IDLE;
                  end
               end
               PH_G_DIR1: begin
                  timer_in = tdec;
                  if (wait_done) begin
                     phase_in = PH_G_FIRST;
                     left_in  = {5'd0, cfg.first_slot_limit};
                     timer_in = '0;
                     step_in  = 1'b0;
                  end
               end
               PH_G_FIRST: begin
                  timer_in = st_timer;
                  step_in  = st_step;
                  left_in  = st_left;
                  if (st_done) begin
                     slot_in  = 3'd1;
                     phase_in = PH_G_PAUSE;
                     timer_in = sat_ticks(cfg.arrival_pause_ticks);
                     step_in  = 1'b0;
                  end
               end
               PH_G_PAUSE: begin
                  timer_in = tdec;
                  if (wait_done) begin
                     if (plan_goal != slot_ff) begin
                        dir_in   = (plan_goal < slot_ff);
                        left_in  = plan_steps;
                        phase_in = PH_G_DIR2;
                        timer_in = sat_ticks(cfg.dir_settle_ticks);
                        step_in  = 1'b0;
                     end else begin
                        phase_in = PH_IDLE;
                     end
                  end
               end
               PH_G_DIR2: begin
                  timer_in = tdec;
                  if (wait_done) begin
                     phase_in = PH_G_MOVE;
                     timer_in = '0;
                     step_in  = 1'b0;
                  end
               end
               PH_G_MOVE: begin
                  timer_in = st_timer;
                  step_in  = st_step;
                  left_in  = st_left;
                  if (st_done) begin
                     slot_in  = goal_ff;
                     phase_in = PH_IDLE;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
                  step_in  = 1'b0;
               end
            endcase
         end
      end else if (phase_ff == PH_IDLE) begin
         if (operation == OP_HOME) begin
            dir_in   = 1'b1;
            phase_in = PH_H_DIR;
            timer_in = sat_ticks(cfg.dir_settle_ticks);
            step_in  = 1'b0;
         end else if (operation == OP_GOTO) begin
            goal_in = clamp_goal;
            if (slot_ff == '0) begin
               dir_in   = 1'b0;
               phase_in = PH_G_DIR1;
               timer_in = sat_ticks(cfg.dir_settle_ticks);
               step_in  = 1'b0;
            end else if (plan_goal != slot_ff) begin
               dir_in   = (plan_goal < slot_ff);
               left_in  = plan_steps;
               phase_in = PH_G_DIR2;
               timer_in = sat_ticks(cfg.dir_settle_ticks);
               step_in  = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         slot_ff  <= '0;
         goal_ff  <= '0;
         left_ff  <= '0;
         timer_ff <= '0;
         dir_ff   <= 1'b0;
         step_ff  <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         slot_ff  <= slot_in;
         goal_ff  <= goal_in;
         left_ff  <= left_in;
         timer_ff <= timer_in;
         dir_ff   <= dir_in;
         step_ff  <= step_in;
      end
   end

   assign rsp_next.step_pin = step_in;
   assign rsp_next.dir_pin  = dir_in;
   assign rsp_next.busy_res = (phase_in != PH_IDLE);
   assign rsp_next.slot     = slot_in;

endmodule

// ===== src/ssp_rsp_buf.sv =====
module ssp_rsp_buf
   import ssp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type rsp_next,
   output logic    can_load,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output rsp_type rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign can_load = ~valid_ff | rsp_tready;
   assign valid_in = load | (valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rsp_next;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_data   = data_ff;

endmodule

// ===== src/slot_stepper_positioner.sv =====
// channel   direction  handshake               payload
// req       in         req_tvalid/req_tready   tuser operation, tdata target/limits
// rsp       out        rsp_tvalid/rsp_tready   tdata step/dir/busy/slot
// csr       in         csr_valid/csr_ready     csr_index, csr_data
//
// one transaction per cycle in unless rsp stalls, its result in the cycle after
// the phase state machine advances once per accepted transaction
// synchronous reset clears the state and the output valid, and reloads the registers
// a stalled result holds in the output register; req is taken while it drains
// csr writes are always accepted
`include "assert_macros.svh"

module slot_stepper_positioner
   import ssp_pkg::*;
#(
   parameter int TICK_TIMER_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // target[2:0], near_limit[3], far_limit[4]
   input  logic [1:0]  req_tuser,   // operation[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // step_pin[0], dir_pin[1], busy_res[2], slot[5:3]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_data
);

   cfg_type cfg;
   rsp_type rsp_next;
   rsp_type rsp_data;
   logic    can_load;
   logic    advance;

   assign csr_ready  = 1'b1;
   assign req_tready = can_load;
   assign advance    = req_tvalid & can_load;

   ssp_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ssp_core #(
      .TICK_TIMER_BITS (TICK_TIMER_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .operation  (req_tuser),
      .target     (req_tdata[2:0]),
      .near_limit (req_tdata[3]),
      .far_limit  (req_tdata[4]),
      .cfg        (cfg),
      .rsp_next   (rsp_next)
   );

   ssp_rsp_buf u_rsp (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .rsp_next   (rsp_next),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data)
   );

   assign rsp_tdata = {2'b00, rsp_data.slot, rsp_data.busy_res,
                       rsp_data.dir_pin, rsp_data.step_pin};

   `SSP_ASSERT(a_accept_gives_rsp, clock, reset, (req_tvalid && req_tready) |=> rsp_tvalid)
   `SSP_ASSERT(a_empty_takes_req, clock, reset, !rsp_tvalid |-> req_tready)
   `SSP_ASSERT(a_step_only_busy, clock, reset, rsp_tvalid |-> !(rsp_tdata[0] && !rsp_tdata[2]))

endmodule

// ===== test/slot_stepper_positioner_test.sv =====
module slot_stepper_positioner_test;
   import ssp_pkg::*;

   localparam logic [1:0] OP_SPARE = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      logic [2:0] tgt;
      logic       near;
      logic       far;
   } req_item_type;

   typedef enum logic [3:0] {
      MV_IDLE, MV_HOME_DIR, MV_HOME_SEEK, MV_HOME_SETTLE, MV_HOME_REVERSE, MV_HOME_BACKOFF,
      MV_GOTO_DIR1, MV_GOTO_FIRST, MV_GOTO_PAUSE, MV_GOTO_DIR2, MV_GOTO_MOVE
   } motion_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [11:0] csr_data = '0;

   slot_stepper_positioner dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // carriage model state
   cfg_type     cfg_q = '{RST_STEPS_PER_SLOT, RST_HOME_BACKOFF, RST_FIRST_LIMIT,
                          RST_DIR_SETTLE, RST_HOME_SETTLE, RST_ARRIVAL_PAUSE,
                          RST_MAX_SLOT, RST_STEP_HALF};
   motion_type  mv = MV_IDLE;
   logic [2:0]  pos_slot = '0;
   logic [2:0]  goal_slot = '0;
   logic [12:0] steps_left = '0;
   logic [11:0] tick_timer = '0;
   logic        dir_q = 1'b0;
   logic        step_q = 1'b0;

   req_item_type pending_items[$];
   rsp_type      expected_status[$];
   req_item_type cur_item;
   rsp_type      mon_want;
   rsp_type      mon_got;

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int queued_items = 0;
   int accepted = 0;
   int rsp_count = 0;
   int mismatches = 0;
   int homes_done = 0;
   int gotos_done = 0;
   int phases_run = 0;
   int stall_left = 0;
   logic hold_off_req = 1'b0;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic void enter_wait(motion_type m, logic [11:0] ticks);
      mv = m;
      tick_timer = ticks;
      step_q = 1'b0;
   endfunction

   function automatic void enter_steps(motion_type m, logic [12:0] count);
      mv = m;
      steps_left = count;
      tick_timer = '0;
      step_q = 1'b0;
   endfunction

   function automatic void plan_move();
      int span;
      if (goal_slot < pos_slot) begin
         dir_q = 1'b1;
         span = int'(pos_slot) - int'(goal_slot);
         steps_left = 13'(int'(cfg_q.steps_per_slot) * span);
         enter_wait(MV_GOTO_DIR2, cfg_q.dir_settle_ticks);
      end else if (goal_slot > pos_slot) begin
         dir_q = 1'b0;
         span = int'(goal_slot) - int'(pos_slot);
         steps_left = 13'(int'(cfg_q.steps_per_slot) * span);
         enter_wait(MV_GOTO_DIR2, cfg_q.dir_settle_ticks);
      end else begin
         pos_slot = goal_slot;
         mv = MV_IDLE;
         gotos_done++;
      end
   endfunction

   // one tick of a stepping phase, returns 1 once the phase is over
   function automatic bit step_tick(bit go_on);
      if (tick_timer != 0) tick_timer--;
      if (tick_timer != 0) return 1'b0;
      if (step_q) begin
         step_q = 1'b0;
         tick_timer = {4'd0, cfg_q.step_half_ticks};
         return 1'b0;
      end
      if (!go_on) return 1'b1;
      step_q = 1'b1;
      tick_timer = {4'd0, cfg_q.step_half_ticks};
      if (steps_left != 0) steps_left--;
      return 1'b0;
   endfunction

   function automatic bit wait_done();
      if (tick_timer != 0) tick_timer--;
      return tick_timer == 0;
   endfunction

   function automatic void advance_tick(logic near, logic far);
      bit any;
      any = near || far;
      case (mv)
         MV_HOME_DIR: begin
            if (wait_done()) enter_steps(MV_HOME_SEEK, '0);
         end
         MV_HOME_SEEK: begin
            if (step_tick(!far)) enter_wait(MV_HOME_SETTLE, cfg_q.home_settle_ticks);
         end
         MV_HOME_SETTLE: begin
            if (wait_done()) begin
               dir_q = 1'b0;
               enter_wait(MV_HOME_REVERSE, cfg_q.dir_settle_ticks);
            end
         end
         MV_HOME_REVERSE: begin
            if (wait_done()) enter_steps(MV_HOME_BACKOFF, {5'd0, cfg_q.home_backoff_steps});
         end
         MV_HOME_BACKOFF: begin
            if (step_tick(steps_left != 0)) begin
               pos_slot = '0;
               mv = MV_IDLE;
               homes_done++;
            end
         end
         MV_GOTO_DIR1: begin
            if (wait_done()) enter_steps(MV_GOTO_FIRST, {5'd0, cfg_q.first_slot_limit});
         end
         MV_GOTO_FIRST: begin
            if (step_tick(steps_left != 0 && !any)) begin
               pos_slot = 3'd1;
               enter_wait(MV_GOTO_PAUSE, cfg_q.arrival_pause_ticks);
            end
         end
         MV_GOTO_PAUSE: begin
            if (wait_done()) plan_move();
         end
         MV_GOTO_DIR2: begin
            if (wait_done()) begin
               mv = MV_GOTO_MOVE;
               tick_timer = '0;
               step_q = 1'b0;
            end
         end
         MV_GOTO_MOVE: begin
            if (step_tick(steps_left != 0 && !any)) begin
               pos_slot = goal_slot;
               mv = MV_IDLE;
               gotos_done++;
            end
         end
         default: begin
            mv = MV_IDLE;
            step_q = 1'b0;
         end
      endcase
   endfunction

   function automatic rsp_type predict_status(req_item_type it);
      rsp_type r;
      if (it.op == OP_TICK) begin
         if (mv != MV_IDLE) advance_tick(it.near, it.far);
      end else if (mv == MV_IDLE) begin
         if (it.op == OP_HOME) begin
            dir_q = 1'b1;
            enter_wait(MV_HOME_DIR, cfg_q.dir_settle_ticks);
         end else if (it.op == OP_GOTO) begin
            goal_slot = (it.tgt > cfg_q.max_slot) ? cfg_q.max_slot : it.tgt;
            if (pos_slot == 0) begin
               dir_q = 1'b0;
               enter_wait(MV_GOTO_DIR1, cfg_q.dir_settle_ticks);
            end else begin
               plan_move();
            end
         end
      end
      r.step_pin = step_q;
      r.dir_pin = dir_q;
      r.busy_res = (mv != MV_IDLE);
      r.slot = pos_slot;
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_status.push_back(predict_status(cur_item));
            accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
               cur_item = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= cur_item.op;
               req_tdata <= {3'b000, cur_item.far, cur_item.near, cur_item.tgt};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result ready, with random idling and the long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (hold_off_req && stall_left == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= 300;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count++;
         mon_got = rsp_type'(rsp_tdata[5:0]);
         if (expected_status.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result transaction: rsp_tdata %h", rsp_tdata);
         end else begin
            mon_want = expected_status.pop_front();
            if (mon_got.step_pin !== mon_want.step_pin || mon_got.dir_pin !== mon_want.dir_pin
                || mon_got.busy_res !== mon_want.busy_res || mon_got.slot !== mon_want.slot
                || rsp_tdata[7:6] !== 2'b00) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at result %0d: expected step %b dir %b busy %b slot %0d,",
                           rsp_count, mon_want.step_pin, mon_want.dir_pin, mon_want.busy_res,
                           mon_want.slot,
                           " got step %b dir %b busy %b slot %0d (tdata %h)",
                           mon_got.step_pin, mon_got.dir_pin, mon_got.busy_res,
                           mon_got.slot, rsp_tdata);
            end
         end
      end
   end

   task automatic add_item(logic [1:0] op, logic [2:0] tgt, logic near, logic far);
      req_item_type it;
      it.op = op;
      it.tgt = tgt;
      it.near = near;
      it.far = far;
      pending_items.push_back(it);
      queued_items++;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_items.size() != 0 || req_tvalid || expected_status.size() != 0);
   endtask

   // ticks with both switches active until the carriage is idle again
   task automatic run_to_idle();
      wait_drained();
      while (mv != MV_IDLE) begin
         repeat (16) add_item(OP_TICK, 3'($urandom), 1'b1, 1'b1);
         wait_drained();
      end
   endtask

   task automatic write_reg(logic [2:0] idx, logic [11:0] val, int w);
      logic [11:0] mask;
      logic [11:0] data;
      mask = 12'((1 << w) - 1);
      data = (12'($urandom) & ~mask) | (val & mask);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_STEPS_PER_SLOT: cfg_q.steps_per_slot = data[9:0];
         REG_HOME_BACKOFF:   cfg_q.home_backoff_steps = data[7:0];
         REG_FIRST_LIMIT:    cfg_q.first_slot_limit = data[7:0];
         REG_DIR_SETTLE:     cfg_q.dir_settle_ticks = data;
         REG_HOME_SETTLE:    cfg_q.home_settle_ticks = data;
         REG_ARRIVAL_PAUSE:  cfg_q.arrival_pause_ticks = data;
         REG_MAX_SLOT:       cfg_q.max_slot = data[2:0];
         default:            cfg_q.step_half_ticks = data[7:0];
      endcase
   endtask

   task automatic set_config(cfg_type c);
      write_reg(REG_STEPS_PER_SLOT, {2'd0, c.steps_per_slot}, 10);
      write_reg(REG_HOME_BACKOFF, {4'd0, c.home_backoff_steps}, 8);
      write_reg(REG_FIRST_LIMIT, {4'd0, c.first_slot_limit}, 8);
      write_reg(REG_DIR_SETTLE, c.dir_settle_ticks, 12);
      write_reg(REG_HOME_SETTLE, c.home_settle_ticks, 12);
      write_reg(REG_ARRIVAL_PAUSE, c.arrival_pause_ticks, 12);
      write_reg(REG_MAX_SLOT, {9'd0, c.max_slot}, 3);
      write_reg(REG_STEP_HALF, {4'd0, c.step_half_ticks}, 8);
      phases_run++;
   endtask

   function automatic cfg_type small_config();
      cfg_type c;
      c.steps_per_slot = 10'($urandom_range(1, 4));
      c.home_backoff_steps = 8'($urandom_range(0, 4));
      c.first_slot_limit = 8'($urandom_range(0, 5));
      c.dir_settle_ticks = 12'($urandom_range(0, 4));
      c.home_settle_ticks = 12'($urandom_range(0, 4));
      c.arrival_pause_ticks = 12'($urandom_range(0, 5));
      c.max_slot = 3'($urandom_range(1, 7));
      c.step_half_ticks = 8'($urandom_range(0, 2));
      return c;
   endfunction

   // a command followed by a run of ticks, or a little noise
   task automatic add_sequence();
      int kind;
      int len;
      int far_at;
      logic [1:0] op;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         len = $urandom_range(1, 4);
         repeat (len) add_item(2'($urandom), 3'($urandom), 1'($urandom), 1'($urandom));
      end else begin
         op = (kind < 35) ? OP_HOME : OP_GOTO;
         add_item(op, 3'($urandom), 1'($urandom), 1'($urandom));
         len = $urandom_range(8, 90);
         far_at = $urandom_range(1, len);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 19) == 0)
               add_item($urandom_range(0, 1) ? OP_HOME : OP_GOTO, 3'($urandom),
                        1'($urandom), 1'($urandom));
            else if (op == OP_HOME)
               add_item(OP_TICK, 3'($urandom), $urandom_range(0, 9) == 0, i >= far_at);
            else
               add_item(OP_TICK, 3'($urandom), $urandom_range(0, 29) == 0,
                        $urandom_range(0, 29) == 0);
         end
      end
   endtask

   task automatic random_phase(int count, bit squeeze);
      int goal;
      goal = queued_items + count;
      while (queued_items < goal) add_sequence();
      if (squeeze) begin
         @(posedge clock);
         hold_off_req <= 1'b1;
         @(posedge clock);
         hold_off_req <= 1'b0;
      end
      run_to_idle();
   endtask

   initial begin
      cfg_type c;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset register values
      add_item(OP_HOME, 3'd0, 1'b0, 1'b0);
      run_to_idle();

      // directed: zero settle, zero half period, busy and unknown commands
      c = '{10'd2, 8'd1, 8'd2, 12'd0, 12'd1, 12'd0, 3'd7, 8'd0};
      set_config(c);
      add_item(OP_TICK, 3'd0, 1'b0, 1'b0);
      add_item(OP_SPARE, 3'd7, 1'b1, 1'b1);
      add_item(OP_HOME, 3'd0, 1'b0, 1'b0);
      add_item(OP_GOTO, 3'd5, 1'b0, 1'b0);
      add_item(OP_SPARE, 3'd2, 1'b0, 1'b0);
      repeat (3) add_item(OP_TICK, 3'd0, 1'b0, 1'b0);
      repeat (2) add_item(OP_TICK, 3'd0, 1'b0, 1'b1);
      repeat (3) add_item(OP_TICK, 3'd0, 1'b0, 1'b0);
      run_to_idle();
      // first slot then goal equal to slot one
      add_item(OP_GOTO, 3'd1, 1'b0, 1'b0);
      repeat (4) add_item(OP_TICK, 3'd0, 1'b0, 1'b0);
      run_to_idle();
      // goto the current slot, then the top slot cut by the near switch
      add_item(OP_GOTO, 3'd1, 1'b0, 1'b0);
      add_item(OP_GOTO, 3'd7, 1'b0, 1'b0);
      repeat (3) add_item(OP_TICK, 3'd0, 1'b0, 1'b0);
      add_item(OP_TICK, 3'd0, 1'b1, 1'b0);
      run_to_idle();
      add_item(OP_GOTO, 3'd0, 1'b0, 1'b0);
      repeat (3) add_item(OP_TICK, 3'd0, 1'b0, 1'b0);
      run_to_idle();
      // zero steps per slot and zero top slot
      c.steps_per_slot = '0;
      c.max_slot = '0;
      set_config(c);
      add_item(OP_GOTO, 3'd6, 1'b0, 1'b0);
      repeat (3) add_item(OP_TICK, 3'd0, 1'b0, 1'b0);
      run_to_idle();

      // sender idles a little, receiver a lot
      tx_idle_pct = 10;
      rx_idle_pct = 79;
      set_config(small_config());
      random_phase(140, 1'b1);

      tx_idle_pct = 79;
      rx_idle_pct = 10;
      set_config(small_config());
      random_phase(140, 1'b0);

      // largest step counts, cut short by the switches
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      c = '{10'd1023, 8'd255, 8'd255, 12'd5, 12'd5, 12'd5, 3'd7, 8'd3};
      set_config(c);
      add_item(OP_GOTO, 3'd7, 1'b0, 1'b0);
      repeat (8) add_item(OP_TICK, 3'($urandom), 1'b0, 1'b0);
      run_to_idle();
      add_item(OP_GOTO, 3'd3, 1'b0, 1'b0);
      repeat (8) add_item(OP_TICK, 3'($urandom), 1'b0, 1'b0);
      run_to_idle();
      c.home_backoff_steps = 8'd0;
      set_config(c);
      add_item(OP_HOME, 3'd0, 1'b0, 1'b0);
      repeat (8) add_item(OP_TICK, 3'($urandom), 1'b0, 1'b0);
      run_to_idle();

      // smallest usable values
      c = '{10'd1, 8'd0, 8'd0, 12'd0, 12'd0, 12'd0, 3'd1, 8'd1};
      set_config(c);
      random_phase(60, 1'b0);

      set_config(small_config());
      random_phase(140, 1'b1);

      wait_drained();
      repeat (20) @(posedge clock);
      $display("ran %0d request transactions through %0d register settings", accepted,
               phases_run);
      $display("carriage finished %0d homing runs and %0d slot moves, %0d results checked",
               homes_done, gotos_done, rsp_count);
      if (mismatches == 0 && expected_status.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #(8 * 4000000);
      $display("FAILURE");
      $finish;
   end

endmodule
